// File: hdl/ucg_pkg.sv
// ucg_pkg: shared types, codes and helpers for the udp checksum generator
// used by ucg_front, ucg_queue, ucg_back and udp_checksum_generator
// no dependencies
package ucg_pkg;

  // input item kinds carried in tuser
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  // protocol constants
  localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
  localparam logic [15:0] UDP_PROTO     = 16'd17;

  // port widths
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 32;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // header sum of nine 16-bit terms fits in 20 bits
  localparam int HSUM_W = 20;

  typedef enum logic {
    OP_START = 1'b0,
    OP_BYTE  = 1'b1
  } op_kind_t;

  // one queued operation for the back end
  typedef struct packed {
    op_kind_t          kind;
    logic              emit;   // start: empty payload, byte: last byte
    logic [HSUM_W-1:0] hsum;   // start only: plain sum of header terms
    logic [15:0]       ulen;   // start only: udp length
    logic [7:0]        data;   // byte only
  } q_entry_t;

  // 16-bit one's-complement add with end-around carry
  function automatic logic [15:0] oc_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  // fold a 20-bit plain sum down to 16 bits one's complement
  function automatic logic [15:0] fold20(input logic [HSUM_W-1:0] x);
    logic [16:0] t;
    t = {1'b0, x[15:0]} + {13'd0, x[19:16]};
    return t[15:0] + {15'd0, t[16]};
  endfunction

endpackage

// File: hdl/ucg_front.sv
// ucg_front: accepts input items, tracks the open packet and builds queue entries
// holds the source address register and forms the header sum
// depends on ucg_pkg
module ucg_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [31:0]                  cfg_wr_data,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // dest_address[31:0], source_port[47:32], dest_port[63:48],
  // payload_length[79:64], data_byte[87:80]
  input  logic [ucg_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                         in_tuser,   // kind[0]
  input  logic                         q_full,
  output logic                         q_push,
  output ucg_pkg::q_entry_t            q_wdata
);
  import ucg_pkg::*;

  logic [31:0] src_addr_r;
  logic        open_r, open_nxt;
  logic [15:0] left_r, left_nxt;

  logic [31:0] dst_addr;
  logic [15:0] sport, dport, plen, ulen;
  logic [7:0]  dbyte;
  logic        accept;

  // field unpacking
  assign dst_addr = in_tdata[31:0];
  assign sport    = in_tdata[47:32];
  assign dport    = in_tdata[63:48];
  assign plen     = in_tdata[79:64];
  assign dbyte    = in_tdata[87:80];
  assign ulen     = plen + UDP_HDR_BYTES;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // classify the item and build the queue entry
  always_comb begin
    open_nxt        = open_r;
    left_nxt        = left_r;
    q_push          = 1'b0;
    q_wdata.kind    = OP_BYTE;
    q_wdata.emit    = 1'b0;
    q_wdata.hsum    = {4'd0, src_addr_r[31:16]} + {4'd0, src_addr_r[15:0]}
                    + {4'd0, dst_addr[31:16]} + {4'd0, dst_addr[15:0]}
                    + {4'd0, UDP_PROTO} + {4'd0, ulen} + {4'd0, ulen}
                    + {4'd0, sport} + {4'd0, dport};
    q_wdata.ulen    = ulen;
    q_wdata.data    = dbyte;
    if (accept) begin
      if (in_tuser == KIND_START) begin
        q_push       = 1'b1;
        q_wdata.kind = OP_START;
        q_wdata.emit = (plen == 16'd0);
        open_nxt     = (plen != 16'd0);
        left_nxt     = plen;
      end else if (open_r) begin
        q_push       = 1'b1;
        q_wdata.kind = OP_BYTE;
        q_wdata.emit = (left_r == 16'd1);
        left_nxt     = left_r - 16'd1;
        if (left_r == 16'd1) begin
          open_nxt = 1'b0;
        end
      end
    end
  end

  // packet tracking and source address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_addr_r <= '0;
      open_r     <= 1'b0;
      left_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        src_addr_r <= cfg_wr_data;
      end
      open_r <= open_nxt;
      left_r <= left_nxt;
    end
  end

endmodule

// File: hdl/ucg_queue.sv
// ucg_queue: small fifo of operations between front and back
// depends on ucg_pkg
module ucg_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ucg_pkg::q_entry_t wdata,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output ucg_pkg::q_entry_t rdata
);
  import ucg_pkg::*;

  q_entry_t         mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]  count_r, count_nxt;

  assign full  = (count_r == Q_CW'(Q_DEPTH));
  assign valid = (count_r != '0);
  assign rdata = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: hdl/ucg_back.sv
// ucg_back: runs queued operations on the checksum accumulator and drives results
// owns the output register
// depends on ucg_pkg
module ucg_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  ucg_pkg::q_entry_t             q_rdata,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // checksum[15:0], udp_length[31:16]
  output logic [ucg_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ucg_pkg::*;

  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        odd_r, odd_nxt;
  logic [15:0] len_r, len_nxt;
  logic        oval_r, oval_nxt;
  logic [OUT_TDATA_W-1:0] odata_r, odata_nxt;

  logic        is_start;
  logic [15:0] start_sum, byte_sum, word;
  logic        can_out;

  assign is_start  = (q_rdata.kind == OP_START);
  assign start_sum = fold20(q_rdata.hsum);
  // pair bytes big-endian, pad an odd last byte with zero
  assign word      = odd_r ? {held_r, q_rdata.data} : {q_rdata.data, 8'h00};
  assign byte_sum  = (odd_r || q_rdata.emit) ? oc_add16(sum_r, word) : sum_r;
  assign can_out   = !oval_r || out_tready;
  assign q_pop     = q_valid && (!q_rdata.emit || can_out);

  // execute one operation per cycle; an emitting one waits for the output register
  always_comb begin
    sum_nxt   = sum_r;
    held_nxt  = held_r;
    odd_nxt   = odd_r;
    len_nxt   = len_r;
    oval_nxt  = oval_r && !out_tready;
    odata_nxt = odata_r;
    if (q_pop) begin
      if (is_start) begin
        sum_nxt = start_sum;
        odd_nxt = 1'b0;
        len_nxt = q_rdata.ulen;
      end else begin
        sum_nxt = byte_sum;
        odd_nxt = q_rdata.emit ? 1'b0 : !odd_r;
        if (!odd_r) begin
          held_nxt = q_rdata.data;
        end
      end
      if (q_rdata.emit) begin
        oval_nxt  = 1'b1;
        odata_nxt = is_start ? {q_rdata.ulen, ~start_sum} : {len_r, ~byte_sum};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      odd_r  <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      odd_r  <= odd_nxt;
      oval_r <= oval_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sum_r   <= sum_nxt;
    held_r  <= held_nxt;
    len_r   <= len_nxt;
    odata_r <= odata_nxt;
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = odata_r;

endmodule

// File: hdl/udp_checksum_generator.sv
// udp_checksum_generator: udp length and checksum over pseudo-header, header and payload
// one item per cycle while the queue is not full; a packet's result is registered once its last
// item leaves the queue, held in an output register while the 4-entry queue keeps taking items
// throughput is set by the combinational 16-bit end-around add in the back end
// synchronous active-low reset clears queue, packet tracking, source address and output valid
// depends on ucg_pkg, ucg_front, ucg_queue, ucg_back
module udp_checksum_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [31:0]                   cfg_wr_data,   // source_address
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // dest_address[31:0], source_port[47:32], dest_port[63:48],
  // payload_length[79:64], data_byte[87:80]
  input  logic [ucg_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                          in_tuser,      // kind[0]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // checksum[15:0], udp_length[31:16]
  output logic [ucg_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ucg_pkg::*;

  logic     q_full, q_push, q_pop, q_valid;
  q_entry_t q_wdata, q_rdata;

  // front end: accept and classify
  ucg_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  // operation queue
  ucg_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  // back end: accumulate and emit
  ucg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
